// ----- hw/rtl/min_jerk_speed_curve_unit_macros.svh -----
// Assertion helpers for the speed curve unit.
`ifndef MIN_JERK_SPEED_CURVE_UNIT_MACROS_SVH
`define MIN_JERK_SPEED_CURVE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define MJSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MJSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mjsc_pkg.sv -----
package mjsc_pkg;

    localparam int TICK_RATE = 1000;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_STOP = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    // Which division is running / being stored.
    typedef enum logic [2:0] {
        SEL_STEPS = 3'd0,
        SEL_FRAC  = 3'd1,
        SEL_TA2   = 3'd2,
        SEL_TA2S  = 3'd3,
        SEL_TA    = 3'd4,
        SEL_TAS   = 3'd5,
        SEL_TB    = 3'd6,
        SEL_POS   = 3'd7
    } t_div_sel;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_SET_CHK   = 10'b00_0000_0010,
        S_STOP      = 10'b00_0000_0100,
        S_TICK      = 10'b00_0000_1000,
        S_MUL_LO    = 10'b00_0001_0000,
        S_MUL_HI    = 10'b00_0010_0000,
        S_VEL_UPD   = 10'b00_0100_0000,
        S_DIV_START = 10'b00_1000_0000,
        S_DIV_WAIT  = 10'b01_0000_0000,
        S_DIV_STORE = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     set_triv;
        logic     set_init;
        logic     stop;
        logic     tick_acc;
        logic     tick_done;
        logic     mul_lo;
        logic     mul_hi;
        logic     vel_upd;
        logic     div_start;
        logic     div_store;
        t_div_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic trivial;
        logic div_done;
        logic quot_zero;
        logic steps_left_zero;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- hw/rtl/mjsc_div.sv -----
module mjsc_div #(
    parameter int DW = 72
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [31:0]   i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [31:0]   r_rem;
    logic [31:0]   r_dsr;
    logic [32:0]   w_trial;
    logic          w_ge;

    // restoring, one quotient bit per cycle, quotient shifts in behind the dividend
    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], w_ge};
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_dsr}) : w_trial[31:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- hw/rtl/mjsc_datapath.sv -----
module mjsc_datapath #(
    parameter int FRACTION_BITS    = 32,
    parameter int STEP_COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mjsc_pkg::t_dp_cmd  i_cmd,
    output mjsc_pkg::t_dp_stat o_stat,
    input  logic [159:0]       i_tdata,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    output logic [95:0]        o_m_tdata,
    output logic               o_m_done
);

    localparam int F     = FRACTION_BITS;
    localparam int SCW   = STEP_COUNT_WIDTH;
    localparam int DIV_W = (40 + F > 64) ? 40 + F : 64;

    localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] HI_LIM = MAX64 >> (32 - F);
    localparam logic [DIV_W-1:0] STEP_MAX = (DIV_W'(1) << SCW) - DIV_W'(1);
    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    // reciprocal of the tick rate, exact for 26-bit partial dividends
    localparam logic [26:0] K_RECIP = 27'(((64'd1 << 36) + 64'(mjsc_pkg::TICK_RATE)
                                           - 64'd1) / 64'(mjsc_pkg::TICK_RATE));

    function automatic logic signed [63:0] f_sat_add(logic signed [63:0] a,
                                                     logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (!b[63] && (b != 64'sd0) && (s > SUM_MAX)) begin
            return SUM_MAX[63:0];
        end else if (b[63] && (s < -SUM_MAX)) begin
            return 64'(-SUM_MAX);
        end else begin
            return s[63:0];
        end
    endfunction

    function automatic logic [31:0] f_out32(logic signed [63:0] q);
        logic [63:0] m;
        logic [63:0] v;
        m = q[63] ? 64'(64'd0 - q) : q;
        v = m >> F;
        if (!q[63]) begin
            return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
        end else begin
            return (v > 64'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - v[31:0]);
        end
    endfunction

    logic signed [31:0] r_in_pos, r_in_v0, r_in_v1, r_in_a0, r_in_rate;
    logic signed [63:0] r_pos, r_vel, r_acc, r_ad, r_ads;
    logic [31:0]        r_sf;
    logic signed [31:0] r_final;
    logic [SCW-1:0]     r_steps_left;
    logic [SCW-1:0]     r_steps;
    logic [62:0]        r_t;
    logic [63:0]        r_lo, r_hi;
    logic [31:0]        r_acc_out;
    logic               r_o_valid;
    logic [95:0]        r_o_data;
    logic               r_o_done;
    logic [63:0]        r_k_num;
    logic [63:0]        r_k_quot;
    logic [9:0]         r_k_rem;
    logic [2:0]         r_k_cnt;
    logic               r_k_busy;
    logic               r_k_done;

    logic signed [32:0] w_d;
    logic signed [42:0] w_d1000;
    logic [42:0]        w_d1000_mag;
    logic signed [37:0] w_a, w_b;
    logic [37:0]        w_a_mag, w_b_mag;
    logic [31:0]        w_rate_mag;
    logic [63:0]        w_vel_mag, w_acc_mag;
    logic [DIV_W-1:0]   w_dvd;
    logic [31:0]        w_dsr;
    logic               w_div_start;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_q;
    logic [62:0]        w_q63;
    logic [63:0]        w_q_neg;
    logic [31:0]        w_mul_a;
    logic [63:0]        w_prod;
    logic [63:0]        w_mf_lo, w_mf_sh, w_mf_res;
    logic signed [63:0] w_mf_signed;
    logic signed [63:0] w_pos_step, w_pos_new;
    logic signed [63:0] w_qb;
    logic               w_k_start;
    logic [25:0]        w_k_part;
    logic [52:0]        w_k_prod;
    logic [15:0]        w_k_digit;
    logic [9:0]         w_k_rem;

    assign w_d         = 33'(r_in_v1) - 33'(r_in_v0);
    assign w_d1000     = 43'(w_d) * 43'sd1000;
    assign w_d1000_mag = w_d1000[42] ? 43'(43'd0 - w_d1000) : w_d1000;
    assign w_a         = 38'(r_in_a0) * 38'sd3 - 38'(w_d) * 38'sd6;
    assign w_b         = 38'(w_d) * 38'sd6 - 38'(r_in_a0) * 38'sd4;
    assign w_a_mag     = w_a[37] ? 38'(38'd0 - w_a) : w_a;
    assign w_b_mag     = w_b[37] ? 38'(38'd0 - w_b) : w_b;
    assign w_rate_mag  = r_in_rate[31] ? 32'(32'd0 - r_in_rate) : r_in_rate;
    assign w_vel_mag   = r_vel[63] ? 64'(64'd0 - r_vel) : r_vel;
    assign w_acc_mag   = r_acc[63] ? 64'(64'd0 - r_acc) : r_acc;

    always_comb begin
        w_dsr = 32'(r_steps);
        case (i_cmd.sel)
            mjsc_pkg::SEL_STEPS: begin
                w_dvd = DIV_W'(w_d1000_mag);
                w_dsr = w_rate_mag;
            end
            mjsc_pkg::SEL_FRAC:  w_dvd = DIV_W'(1) << F;
            mjsc_pkg::SEL_TA2:   w_dvd = DIV_W'(w_a_mag) << (F + 1);
            mjsc_pkg::SEL_TA2S:  w_dvd = DIV_W'(r_t);
            mjsc_pkg::SEL_TA:    w_dvd = DIV_W'(w_a_mag) << F;
            mjsc_pkg::SEL_TAS:   w_dvd = DIV_W'(r_t);
            mjsc_pkg::SEL_TB:    w_dvd = DIV_W'(w_b_mag) << F;
            default:             w_dvd = '0;
        endcase
    end

    // the position step goes to the divide-by-tick-rate unit below instead
    assign w_div_start = i_cmd.div_start && (i_cmd.sel != mjsc_pkg::SEL_POS);
    assign w_k_start   = i_cmd.div_start && (i_cmd.sel == mjsc_pkg::SEL_POS);

    mjsc_div #(.DW(DIV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dsr),
        .o_done     (w_div_done),
        .o_quot     (w_q)
    );

    // |vel| / tick rate, one 16-bit digit per cycle by reciprocal multiply
    assign w_k_part  = {r_k_rem, r_k_num[63:48]};
    assign w_k_prod  = 53'(w_k_part) * 53'(K_RECIP);
    assign w_k_digit = w_k_prod[51:36];
    assign w_k_rem   = 10'(w_k_part - 26'(w_k_digit) * 26'(mjsc_pkg::TICK_RATE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_busy <= 1'b0;
            r_k_done <= 1'b0;
            r_k_cnt  <= '0;
        end else begin
            r_k_done <= 1'b0;
            if (w_k_start) begin
                r_k_busy <= 1'b1;
                r_k_cnt  <= 3'd4;
            end else if (r_k_busy) begin
                r_k_cnt <= r_k_cnt - 3'd1;
                if (r_k_cnt == 3'd1) begin
                    r_k_busy <= 1'b0;
                    r_k_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_k_start) begin
            r_k_num  <= w_vel_mag;
            r_k_rem  <= '0;
            r_k_quot <= '0;
        end else if (r_k_busy) begin
            r_k_num  <= {r_k_num[47:0], 16'd0};
            r_k_rem  <= w_k_rem;
            r_k_quot <= {r_k_quot[47:0], w_k_digit};
        end
    end

    assign w_q63   = (|w_q[DIV_W-1:63]) ? {63{1'b1}} : w_q[62:0];
    assign w_q_neg = 64'(64'd0 - w_q[63:0]);
    assign w_qb    = w_b[37] ? 64'(64'd0 - {1'b0, w_q63}) : {1'b0, w_q63};

    assign w_pos_step = r_vel[63] ? 64'(64'd0 - r_k_quot) : r_k_quot;
    assign w_pos_new  = f_sat_add(r_pos, w_pos_step);

    // one 32x32 multiplier, low then high half of |acc|
    assign w_mul_a = i_cmd.mul_hi ? w_acc_mag[63:32] : w_acc_mag[31:0];
    assign w_prod  = 64'(w_mul_a) * 64'(r_sf);

    always_comb begin
        w_mf_lo = r_lo >> F;
        w_mf_sh = r_hi << (32 - F);
        if (r_hi > HI_LIM) begin
            w_mf_res = MAX64;
        end else if (w_mf_sh > MAX64 - w_mf_lo) begin
            w_mf_res = MAX64;
        end else begin
            w_mf_res = w_mf_sh + w_mf_lo;
        end
        w_mf_signed = r_acc[63] ? 64'(64'd0 - w_mf_res) : w_mf_res;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_pos  <= i_tdata[31:0];
            r_in_v0   <= i_tdata[63:32];
            r_in_v1   <= i_tdata[95:64];
            r_in_a0   <= i_tdata[127:96];
            r_in_rate <= i_tdata[159:128];
        end
        if (i_cmd.mul_lo) begin
            r_lo      <= w_prod;
            r_acc_out <= f_out32(r_acc);
        end
        if (i_cmd.mul_hi) begin
            r_hi <= w_prod;
        end
        if (i_cmd.tick_done) begin
            r_acc_out <= '0;
        end
        if (i_cmd.div_store) begin
            case (i_cmd.sel)
                mjsc_pkg::SEL_STEPS: r_steps <= (w_q > STEP_MAX) ? '1 : w_q[SCW-1:0];
                mjsc_pkg::SEL_TA2:   r_t <= w_q63;
                mjsc_pkg::SEL_TA:    r_t <= w_q63;
                mjsc_pkg::SEL_POS:   r_o_data <= {r_acc_out, f_out32(r_vel),
                                                  f_out32(w_pos_new)};
                default: ;
            endcase
        end
        if (i_cmd.div_store && (i_cmd.sel == mjsc_pkg::SEL_POS)) begin
            r_o_done <= (r_steps_left == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_vel        <= '0;
            r_acc        <= '0;
            r_ad         <= '0;
            r_ads        <= '0;
            r_sf         <= '0;
            r_final      <= '0;
            r_steps_left <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cmd.div_store && (i_cmd.sel == mjsc_pkg::SEL_POS)) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.set_triv) begin
                r_steps_left <= '0;
            end
            if (i_cmd.set_init) begin
                r_pos   <= 64'(r_in_pos) <<< F;
                r_vel   <= 64'(r_in_v0) <<< F;
                r_acc   <= 64'(r_in_a0) <<< F;
                r_final <= r_in_v1;
            end
            if (i_cmd.stop) begin
                r_pos        <= 64'(r_in_pos) <<< F;
                r_vel        <= '0;
                r_final      <= '0;
                r_steps_left <= '0;
            end
            if (i_cmd.tick_acc) begin
                r_steps_left <= r_steps_left - SCW'(1);
                r_acc        <= f_sat_add(r_acc, r_ad);
                r_ad         <= f_sat_add(r_ad, r_ads);
            end
            if (i_cmd.tick_done) begin
                r_vel <= 64'(r_final) <<< F;
            end
            if (i_cmd.vel_upd) begin
                r_vel <= f_sat_add(r_vel, w_mf_signed);
            end
            if (i_cmd.div_store) begin
                case (i_cmd.sel)
                    mjsc_pkg::SEL_STEPS: begin
                        r_steps_left <= (w_q > STEP_MAX) ? '1 : w_q[SCW-1:0];
                        if (w_q == '0) begin
                            r_sf  <= '0;
                            r_ad  <= '0;
                            r_ads <= '0;
                        end
                    end
                    mjsc_pkg::SEL_FRAC:
                        r_sf <= (|w_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : w_q[31:0];
                    mjsc_pkg::SEL_TA2S: r_ads <= w_a[37] ? w_q_neg : w_q[63:0];
                    mjsc_pkg::SEL_TAS:  r_ad  <= w_a[37] ? w_q_neg : w_q[63:0];
                    mjsc_pkg::SEL_TB:   r_ad  <= f_sat_add(r_ad, w_qb);
                    mjsc_pkg::SEL_POS:  r_pos <= w_pos_new;
                    default: ;
                endcase
            end
        end
    end

    assign o_stat.trivial         = (r_in_rate == '0) || (r_in_v1 == r_in_v0);
    assign o_stat.div_done        = w_div_done || r_k_done;
    assign o_stat.quot_zero       = (w_q == '0);
    assign o_stat.steps_left_zero = (r_steps_left == '0);
    assign o_stat.out_free        = !r_o_valid || i_m_tready;

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_done   = r_o_done;

endmodule

// ----- hw/rtl/mjsc_ctrl.sv -----
module mjsc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic [1:0]         i_opcode,
    output logic               o_s_tready,
    input  mjsc_pkg::t_dp_stat i_stat,
    output mjsc_pkg::t_dp_cmd  o_cmd
);

    mjsc_pkg::t_state   r_state, n_state;
    mjsc_pkg::t_div_sel r_sel, n_sel;

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_s_tready = 1'b0;
        case (r_state)
            mjsc_pkg::S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    case (mjsc_pkg::t_opcode'(i_opcode))
                        mjsc_pkg::OP_TICK: n_state = mjsc_pkg::S_TICK;
                        mjsc_pkg::OP_SET:  n_state = mjsc_pkg::S_SET_CHK;
                        mjsc_pkg::OP_STOP: n_state = mjsc_pkg::S_STOP;
                        default:           n_state = mjsc_pkg::S_IDLE;
                    endcase
                end
            end
            mjsc_pkg::S_SET_CHK: begin
                if (i_stat.trivial) begin
                    o_cmd.set_triv = 1'b1;
                    n_state        = mjsc_pkg::S_IDLE;
                end else begin
                    o_cmd.set_init = 1'b1;
                    n_sel          = mjsc_pkg::SEL_STEPS;
                    n_state        = mjsc_pkg::S_DIV_START;
                end
            end
            mjsc_pkg::S_STOP: begin
                o_cmd.stop = 1'b1;
                n_state    = mjsc_pkg::S_IDLE;
            end
            mjsc_pkg::S_TICK: begin
                if (i_stat.steps_left_zero) begin
                    o_cmd.tick_done = 1'b1;
                    n_sel           = mjsc_pkg::SEL_POS;
                    n_state         = mjsc_pkg::S_DIV_START;
                end else begin
                    o_cmd.tick_acc = 1'b1;
                    n_state        = mjsc_pkg::S_MUL_LO;
                end
            end
            mjsc_pkg::S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = mjsc_pkg::S_MUL_HI;
            end
            mjsc_pkg::S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = mjsc_pkg::S_VEL_UPD;
            end
            mjsc_pkg::S_VEL_UPD: begin
                o_cmd.vel_upd = 1'b1;
                n_sel         = mjsc_pkg::SEL_POS;
                n_state       = mjsc_pkg::S_DIV_START;
            end
            mjsc_pkg::S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = mjsc_pkg::S_DIV_WAIT;
            end
            mjsc_pkg::S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = mjsc_pkg::S_DIV_STORE;
                end
            end
            mjsc_pkg::S_DIV_STORE: begin
                // position result waits here until the output register is free
                if ((r_sel != mjsc_pkg::SEL_POS) || i_stat.out_free) begin
                    o_cmd.div_store = 1'b1;
                    n_state         = mjsc_pkg::S_DIV_START;
                    case (r_sel)
                        mjsc_pkg::SEL_STEPS: begin
                            n_sel = mjsc_pkg::SEL_FRAC;
                            if (i_stat.quot_zero) begin
                                n_state = mjsc_pkg::S_IDLE;
                            end
                        end
                        mjsc_pkg::SEL_FRAC: n_sel   = mjsc_pkg::SEL_TA2;
                        mjsc_pkg::SEL_TA2:  n_sel   = mjsc_pkg::SEL_TA2S;
                        mjsc_pkg::SEL_TA2S: n_sel   = mjsc_pkg::SEL_TA;
                        mjsc_pkg::SEL_TA:   n_sel   = mjsc_pkg::SEL_TAS;
                        mjsc_pkg::SEL_TAS:  n_sel   = mjsc_pkg::SEL_TB;
                        default:            n_state = mjsc_pkg::S_IDLE;
                    endcase
                end
            end
            default: n_state = mjsc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mjsc_pkg::S_IDLE;
            r_sel   <= mjsc_pkg::SEL_STEPS;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

endmodule

// ----- hw/rtl/min_jerk_speed_curve_unit.sv -----
// Minimum-jerk velocity ramp generator in Q(64-F).F fixed point. One input
// transaction at a time: a tick that finds a ramp running also passes through
// the multiply and velocity-update states before its position step; the
// position step divides |velocity| by the tick rate in four 16-bit digit
// steps. Set reference runs up to seven passes of the shared restoring
// divider, one bit per cycle over a DW-bit dividend, DW = max(64, 40+F);
// that divider sets the set-reference time. Only tick produces a result; a
// result waiting on the output does not hold back the next input until the
// following tick needs the output register.
module min_jerk_speed_curve_unit #(
    parameter int FRACTION_BITS    = 32,
    parameter int STEP_COUNT_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // position_in, start_velocity, target_velocity, start_accel, accel_rate
    input  logic [159:0] s_axis_tdata,
    // opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // position, velocity, acceleration
    output logic [95:0]  m_axis_tdata,
    // done_res
    output logic [0:0]   m_axis_tuser
);

    mjsc_pkg::t_dp_cmd  w_cmd;
    mjsc_pkg::t_dp_stat w_stat;

    mjsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    mjsc_datapath #(
        .FRACTION_BITS    (FRACTION_BITS),
        .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_tdata    (s_axis_tdata),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_done   (m_axis_tuser[0])
    );

endmodule

// ----- hw/rtl/mjsc_checker.sv -----
`include "min_jerk_speed_curve_unit_macros.svh"

module mjsc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [159:0] s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    logic w_s_acc;
    logic w_active_op;

    assign w_s_acc     = s_axis_tvalid && s_axis_tready;
    assign w_active_op = s_axis_tuser != mjsc_pkg::OP_NONE;

    `MJSC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `MJSC_ASSERT_NEXT(a_busy_after_item, w_s_acc && w_active_op, !s_axis_tready, "input taken while an item is at work")
    `MJSC_ASSERT_NOW(a_result_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared without work in progress")

endmodule

bind min_jerk_speed_curve_unit mjsc_checker u_chk (.*);
